// ----- hw/rtl/acs_pkg.sv -----
// Shared types, constants and codes of the ADC conversion sequencer.
// No dependencies; compile first.
package acs_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned CFG_W        = 32;
  localparam int unsigned DIV_STEPS    = 16;

  localparam logic [2:0]  REF_CHANNEL = 3'd7;
  localparam logic [11:0] VREF_MV     = 12'd3000;
  localparam logic [3:0]  OVS_MAX     = 4'd8;
  localparam logic [3:0]  SHIFT_BASE  = 4'd4;
  localparam logic [15:0] RES_RESET   = 16'h0000;
  localparam logic [31:0] OVS_RESET   = 32'h8000_0000;
  localparam logic [11:0] CAL_RESET   = 12'h000;
  localparam logic [15:0] SUPPLY_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    CFG_RESOLUTION   = 2'd0,
    CFG_OVERSAMPLING = 2'd1,
    CFG_VREFINT      = 2'd2
  } acs_cfg_e;

  typedef enum logic [1:0] {
    REQ_MEASURE  = 2'd0,
    REQ_COMPLETE = 2'd1,
    REQ_READ     = 2'd2
  } acs_req_e;

  typedef enum logic [1:0] {
    SUP_ZERO = 2'd0,
    SUP_SAT  = 2'd1,
    SUP_QUO  = 2'd2
  } acs_sup_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MULT,
    ST_RANGE,
    ST_DIV,
    ST_SUPPLY,
    ST_SCAN,
    ST_VOLT,
    ST_OUT
  } acs_state_e;

  typedef struct packed {
    logic     load_in;
    logic     do_measure;
    logic     load_num;
    logic     div_init;
    logic     div_step;
    logic     set_supply;
    acs_sup_e supply_sel;
    logic     start_input;
    logic     finish;
    logic     scan_step;
    logic     load_read;
    logic     mul_volts;
    logic     push_out;
  } acs_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       busy;
    logic       phase;
    logic       raw_zero;
    logic       sat;
    logic       div_last;
    logic       scan_hit;
    logic       scan_last;
    logic       out_free;
  } acs_stat_t;

endpackage

// ----- hw/rtl/acs_if.sv -----
// Valid/ready channel interfaces for request beats and result beats.
// No dependencies.
interface acs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  channel;
  logic [15:0] raw_data;

  modport source (output valid, req_type, channel, raw_data, input ready);
  modport sink   (input valid, req_type, channel, raw_data, output ready);
endinterface

interface acs_res_if;
  logic        valid;
  logic        ready;
  logic        start_valid;
  logic [2:0]  start_channel;
  logic [1:0]  start_resolution;
  logic [3:0]  start_oversampling;
  logic        done_valid;
  logic [2:0]  done_channel;
  logic [15:0] sample_value;
  logic [15:0] voltage_mv;
  logic [15:0] vdda_mv;
  logic        busy_res;

  modport source (output valid, start_valid, start_channel, start_resolution,
                  start_oversampling, done_valid, done_channel, sample_value,
                  voltage_mv, vdda_mv, busy_res, input ready);
  modport sink   (input valid, start_valid, start_channel, start_resolution,
                  start_oversampling, done_valid, done_channel, sample_value,
                  voltage_mv, vdda_mv, busy_res, output ready);
endinterface

// ----- hw/rtl/acs_datapath.sv -----
// Datapath: configuration, sequencer state, sample store, supply divider,
// voltage multiplier and result register. Depends on acs_pkg.
module acs_datapath #(
  parameter int unsigned CHANNELS = acs_pkg::CHANNELS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [acs_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [1:0]               req_type_i,
  input  logic [2:0]               channel_i,
  input  logic [15:0]              raw_data_i,
  input  acs_pkg::acs_cmd_t        cmd_i,
  output acs_pkg::acs_stat_t       stat_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     start_valid_o,
  output logic [2:0]               start_channel_o,
  output logic [1:0]               start_resolution_o,
  output logic [3:0]               start_oversampling_o,
  output logic                     done_valid_o,
  output logic [2:0]               done_channel_o,
  output logic [15:0]              sample_value_o,
  output logic [15:0]              voltage_mv_o,
  output logic [15:0]              vdda_mv_o,
  output logic                     busy_res_o
);
  import acs_pkg::*;

  localparam int unsigned IDX_W = $clog2(CHANNELS);
  localparam int unsigned CH_W  = (IDX_W > 3) ? IDX_W : 3;
  localparam int unsigned DIV_W = $clog2(DIV_STEPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic       v;
    logic [2:0] ch;
    logic [1:0] res;
    logic [3:0] ovs;
  } start_t;

  logic [15:0] res_codes_q;
  logic [31:0] ovs_codes_q;
  logic [11:0] cal_q;

  logic [1:0]  req_q;
  logic [2:0]  ch_q;
  logic [15:0] raw_q;

  logic                busy_q;
  logic [CH_W-1:0]     cur_q;
  logic                phase_q;
  logic [CHANNELS-1:0] pend_q;
  logic [15:0]         samples_q [CHANNELS];
  logic [15:0]         supply_q;

  logic [23:0]      num_q;
  logic [15:0]      rem_q;
  logic [15:0]      qd_q;
  logic [DIV_W-1:0] div_cnt_q;
  logic [IDX_W-1:0] scan_c_q;
  logic [IDX_W-1:0] scan_n_q;

  start_t      r_start_q;
  logic        r_done_v_q;
  logic [2:0]  r_done_ch_q;
  logic [15:0] r_sample_q;
  logic [31:0] prod_q;

  logic        out_v_q;
  start_t      o_start_q;
  logic        o_done_v_q;
  logic [2:0]  o_done_ch_q;
  logic [15:0] o_sample_q;
  logic [15:0] o_volts_q;
  logic [15:0] o_vdda_q;
  logic        o_busy_q;

  logic [CH_W-1:0]  ch_x;
  logic [IDX_W-1:0] ch_idx;
  logic [IDX_W-1:0] cur_idx;
  logic             ch_ok;
  start_t           cur_start;
  logic [3:0]       shamt;
  logic [15:0]      fin_val;
  logic [16:0]      div_t;
  logic             div_ge;
  logic             sat;
  logic             out_free;
  logic             scan_hit;

  function automatic start_t mk_start(logic [CH_W-1:0] c, logic [15:0] rc, logic [31:0] oc);
    start_t s;
    s.v   = 1'b1;
    s.ch  = c[2:0];
    s.res = 2'(rc >> {c[2:0], 1'b0});
    s.ovs = 4'(oc >> {c[2:0], 2'b00});
    if (s.ovs > OVS_MAX) begin
      s.ovs = OVS_MAX;
    end
    if ((c >> 3) != '0) begin
      s.res = '0;
      s.ovs = '0;
    end
    return s;
  endfunction

  function automatic logic [IDX_W-1:0] inc_idx(logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign ch_x      = CH_W'(ch_q);
  assign ch_idx    = ch_x[IDX_W-1:0];
  assign cur_idx   = cur_q[IDX_W-1:0];
  assign ch_ok     = ({29'd0, ch_q} < 32'(CHANNELS));
  assign cur_start = mk_start(cur_q, res_codes_q, ovs_codes_q);
  assign shamt     = SHIFT_BASE + {1'b0, cur_start.res, 1'b0};
  assign fin_val   = raw_q << shamt;
  assign div_t     = {rem_q, qd_q[15]};
  assign div_ge    = (div_t >= {1'b0, raw_q});
  assign sat       = ({8'd0, num_q[23:16]} >= raw_q);
  assign out_free  = !out_v_q || out_ready_i;
  assign scan_hit  = pend_q[scan_c_q];

  always_comb begin
    stat_o.req       = req_q;
    stat_o.busy      = busy_q;
    stat_o.phase     = phase_q;
    stat_o.raw_zero  = (raw_q == '0);
    stat_o.sat       = sat;
    stat_o.div_last  = (div_cnt_q == DIV_LAST);
    stat_o.scan_hit  = scan_hit;
    stat_o.scan_last = (scan_n_q == LAST_IDX);
    stat_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_codes_q <= RES_RESET;
      ovs_codes_q <= OVS_RESET;
      cal_q       <= CAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESOLUTION:   res_codes_q <= cfg_data_i[15:0];
        CFG_OVERSAMPLING: ovs_codes_q <= cfg_data_i[31:0];
        CFG_VREFINT:      cal_q       <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= req_type_i;
      ch_q  <= channel_i;
      raw_q <= raw_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cur_q    <= '0;
      phase_q  <= 1'b0;
      pend_q   <= '0;
      supply_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        samples_q[i] <= '0;
      end
    end else begin
      if (cmd_i.do_measure && ch_ok) begin
        if (busy_q) begin
          pend_q[ch_idx] <= 1'b1;
        end else begin
          busy_q         <= 1'b1;
          cur_q          <= ch_x;
          pend_q[ch_idx] <= 1'b0;
          phase_q        <= 1'b0;
        end
      end
      if (cmd_i.set_supply) begin
        unique case (cmd_i.supply_sel)
          SUP_ZERO: supply_q <= '0;
          SUP_SAT:  supply_q <= SUPPLY_MAX;
          SUP_QUO:  supply_q <= qd_q;
          default:  supply_q <= '0;
        endcase
      end
      if (cmd_i.start_input) begin
        phase_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        samples_q[cur_idx] <= fin_val;
        busy_q             <= 1'b0;
        phase_q            <= 1'b0;
      end
      if (cmd_i.scan_step && scan_hit) begin
        busy_q           <= 1'b1;
        cur_q            <= CH_W'(scan_c_q);
        pend_q[scan_c_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_num) begin
      num_q <= 24'(cal_q) * 24'(VREF_MV);
    end
    if (cmd_i.div_init) begin
      rem_q     <= {8'd0, num_q[23:16]};
      qd_q      <= num_q[15:0];
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= div_ge ? 16'(div_t - {1'b0, raw_q}) : div_t[15:0];
      qd_q      <= {qd_q[14:0], div_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      scan_c_q <= inc_idx(cur_idx);
      scan_n_q <= '0;
    end else if (cmd_i.scan_step && !scan_hit) begin
      scan_c_q <= inc_idx(scan_c_q);
      scan_n_q <= scan_n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      r_start_q   <= '0;
      r_done_v_q  <= 1'b0;
      r_done_ch_q <= '0;
      r_sample_q  <= '0;
      prod_q      <= '0;
    end else begin
      if (cmd_i.do_measure && ch_ok && !busy_q) begin
        r_start_q <= mk_start(CH_W'(REF_CHANNEL), res_codes_q, ovs_codes_q);
      end
      if (cmd_i.start_input) begin
        r_start_q <= mk_start(cur_q, res_codes_q, ovs_codes_q);
      end
      if (cmd_i.finish) begin
        r_done_v_q  <= 1'b1;
        r_done_ch_q <= cur_q[2:0];
        r_sample_q  <= fin_val;
      end
      if (cmd_i.scan_step && scan_hit) begin
        r_start_q <= mk_start(CH_W'(REF_CHANNEL), res_codes_q, ovs_codes_q);
      end
      if (cmd_i.load_read) begin
        r_done_ch_q <= ch_q;
        r_sample_q  <= ch_ok ? samples_q[ch_idx] : '0;
      end
      if (cmd_i.mul_volts) begin
        prod_q <= 32'(r_sample_q) * 32'(supply_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.push_out) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_out) begin
      o_start_q   <= r_start_q;
      o_done_v_q  <= r_done_v_q;
      o_done_ch_q <= r_done_ch_q;
      o_sample_q  <= r_sample_q;
      o_volts_q   <= prod_q[31:16];
      o_vdda_q    <= supply_q;
      o_busy_q    <= busy_q;
    end
  end

  assign out_valid_o          = out_v_q;
  assign start_valid_o        = o_start_q.v;
  assign start_channel_o      = o_start_q.ch;
  assign start_resolution_o   = o_start_q.res;
  assign start_oversampling_o = o_start_q.ovs;
  assign done_valid_o         = o_done_v_q;
  assign done_channel_o       = o_done_ch_q;
  assign sample_value_o       = o_sample_q;
  assign voltage_mv_o         = o_volts_q;
  assign vdda_mv_o            = o_vdda_q;
  assign busy_res_o           = o_busy_q;

endmodule

// ----- hw/rtl/acs_controller.sv -----
// Controller: sequences decode, supply division, pending scan and result
// hand-off for one request beat at a time. Depends on acs_pkg.
module acs_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  acs_pkg::acs_stat_t stat_i,
  output acs_pkg::acs_cmd_t  cmd_o
);
  import acs_pkg::*;

  acs_state_e state_q;
  acs_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.req)
          REQ_MEASURE: begin
            cmd_o.do_measure = 1'b1;
            state_d          = ST_OUT;
          end
          REQ_COMPLETE: begin
            if (stat_i.busy && !stat_i.phase) begin
              state_d = ST_MULT;
            end else if (stat_i.busy) begin
              cmd_o.finish = 1'b1;
              state_d      = ST_SCAN;
            end else begin
              state_d = ST_OUT;
            end
          end
          REQ_READ: begin
            cmd_o.load_read = 1'b1;
            state_d         = ST_VOLT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_MULT: begin
        cmd_o.load_num = 1'b1;
        state_d        = ST_RANGE;
      end
      ST_RANGE: begin
        priority if (stat_i.raw_zero) begin
          cmd_o.set_supply  = 1'b1;
          cmd_o.supply_sel  = SUP_ZERO;
          cmd_o.start_input = 1'b1;
          state_d           = ST_OUT;
        end else if (stat_i.sat) begin
          cmd_o.set_supply  = 1'b1;
          cmd_o.supply_sel  = SUP_SAT;
          cmd_o.start_input = 1'b1;
          state_d           = ST_OUT;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_SUPPLY;
        end
      end
      ST_SUPPLY: begin
        cmd_o.set_supply  = 1'b1;
        cmd_o.supply_sel  = SUP_QUO;
        cmd_o.start_input = 1'b1;
        state_d           = ST_OUT;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.mul_volts = 1'b1;
        if (stat_i.scan_hit || stat_i.scan_last) begin
          state_d = ST_OUT;
        end
      end
      ST_VOLT: begin
        cmd_o.mul_volts = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/adc_conversion_sequencer.sv -----
// ADC conversion sequencer top level: controller and datapath joined by
// command and status structs. Depends on acs_pkg, acs_if, acs_controller, acs_datapath.
//
// One request beat is worked at a time and gives exactly one result beat.
// A measure or an ignored request goes from decode straight to the output
// state, a read through the voltage multiply. A reference completion forms
// the calibration product, makes a range check, then runs a restoring divider
// that produces one quotient bit per cycle for a 16-bit quotient and sets the
// supply; with a zero reading or a saturated supply it skips the divider. A
// channel completion stores the sample, then the round-robin scan of the
// pending mask visits channels until one is pending, at most CHANNELS. The
// output state waits for a free result register, and the next request beat is
// taken only after the push. The result register parts the two channels: a
// new request is taken while the previous result waits.
module adc_conversion_sequencer #(
  parameter int unsigned CHANNELS = acs_pkg::CHANNELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [acs_pkg::CFG_W-1:0] cfg_data_i,
  acs_req_if.sink                   req_i,
  acs_res_if.source                 res_o
);
  import acs_pkg::*;

  acs_cmd_t  cmd;
  acs_stat_t stat;

  acs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  acs_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .req_type_i           (req_i.req_type),
    .channel_i            (req_i.channel),
    .raw_data_i           (req_i.raw_data),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .out_ready_i          (res_o.ready),
    .out_valid_o          (res_o.valid),
    .start_valid_o        (res_o.start_valid),
    .start_channel_o      (res_o.start_channel),
    .start_resolution_o   (res_o.start_resolution),
    .start_oversampling_o (res_o.start_oversampling),
    .done_valid_o         (res_o.done_valid),
    .done_channel_o       (res_o.done_channel),
    .sample_value_o       (res_o.sample_value),
    .voltage_mv_o         (res_o.voltage_mv),
    .vdda_mv_o            (res_o.vdda_mv),
    .busy_res_o           (res_o.busy_res)
  );

endmodule

// ----- sim/tb_adc_conversion_sequencer.sv -----
`timescale 1ns / 1ps
// Testbench for adc_conversion_sequencer: directed and random request beats with
// a cycle-free predictor of the sequencer, result beats checked in order.
// Depends on acs_pkg, acs_if and the adc_conversion_sequencer RTL.
module tb_adc_conversion_sequencer;
  import acs_pkg::*;

  localparam int unsigned NCH          = CHANNELS_DEF;
  localparam logic [1:0]  REQ_RESERVED = 2'd3;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned PHASE_BEATS  = 220;

  typedef struct packed {
    logic        start_valid;
    logic [2:0]  start_ch;
    logic [1:0]  start_res;
    logic [3:0]  start_ovs;
    logic        done_valid;
    logic [2:0]  done_ch;
    logic [15:0] sample;
    logic [15:0] volts;
    logic [15:0] vdda;
    logic        busy;
  } seq_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;

  acs_req_if req_bus ();
  acs_res_if res_bus ();

  adc_conversion_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus),
    .res_o      (res_bus)
  );

  // sequencer model state and register copies
  logic        seq_busy   = 1'b0;
  logic [2:0]  conv_ch    = '0;
  logic        on_input   = 1'b0;
  logic [7:0]  queued_ch  = '0;
  logic [15:0] sample_mem [NCH] = '{default: '0};
  logic [15:0] vdda_model = '0;
  logic [15:0] res_cfg    = RES_RESET;
  logic [31:0] ovs_cfg    = OVS_RESET;
  logic [11:0] cal_cfg    = CAL_RESET;

  seq_beat_t   awaited_results [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          src_idle_on  = 1'b1;
  bit          sink_stall_on = 1'b1;
  bit          hold_toggle  = 1'b0;
  bit          hold_seen    = 1'b0;
  int unsigned hold_left    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [1:0] res_code_of(logic [2:0] c);
    return res_cfg[2*c +: 2];
  endfunction

  function automatic logic [3:0] ovs_code_of(logic [2:0] c);
    logic [3:0] v;
    v = ovs_cfg[4*c +: 4];
    return (v > OVS_MAX) ? OVS_MAX : v;
  endfunction

  function automatic logic [9:0] start_fields(logic [2:0] c);
    return {1'b1, c, res_code_of(c), ovs_code_of(c)};
  endfunction

  function automatic logic [15:0] volts_of(logic [15:0] s);
    logic [31:0] p;
    p = 32'(s) * 32'(vdda_model);
    return p[31:16];
  endfunction

  function automatic seq_beat_t predict_sequencer_beat(logic [1:0] rt, logic [2:0] ch,
                                                       logic [15:0] raw);
    seq_beat_t   b;
    logic [31:0] wide;
    logic [2:0]  fin;
    logic [2:0]  c;
    int          k;
    b = '0;
    case (rt)
      REQ_MEASURE: begin
        if (seq_busy) begin
          queued_ch[ch] = 1'b1;
        end else begin
          seq_busy      = 1'b1;
          conv_ch       = ch;
          queued_ch[ch] = 1'b0;
          on_input      = 1'b0;
          {b.start_valid, b.start_ch, b.start_res, b.start_ovs} = start_fields(REF_CHANNEL);
        end
      end
      REQ_COMPLETE: begin
        if (seq_busy && !on_input) begin
          wide = 32'(VREF_MV) * 32'(cal_cfg);
          if (raw == '0) begin
            vdda_model = '0;
          end else begin
            wide = wide / 32'(raw);
            vdda_model = (wide > 32'(SUPPLY_MAX)) ? SUPPLY_MAX : wide[15:0];
          end
          on_input = 1'b1;
          {b.start_valid, b.start_ch, b.start_res, b.start_ovs} = start_fields(conv_ch);
        end else if (seq_busy) begin
          fin  = conv_ch;
          wide = {16'b0, raw} << (32'(SHIFT_BASE) + 2 * 32'(res_code_of(fin)));
          sample_mem[fin] = wide[15:0];
          b.done_valid = 1'b1;
          b.done_ch    = fin;
          b.sample     = wide[15:0];
          b.volts      = volts_of(wide[15:0]);
          seq_busy     = 1'b0;
          on_input     = 1'b0;
          // round robin, finished channel last
          for (k = 1; k <= NCH; k++) begin
            c = fin + k[2:0];
            if (queued_ch[c]) begin
              seq_busy     = 1'b1;
              conv_ch      = c;
              queued_ch[c] = 1'b0;
              {b.start_valid, b.start_ch, b.start_res, b.start_ovs} = start_fields(REF_CHANNEL);
              break;
            end
          end
        end
      end
      REQ_READ: begin
        b.done_ch = ch;
        b.sample  = sample_mem[ch];
        b.volts   = volts_of(sample_mem[ch]);
      end
      default: ;
    endcase
    b.vdda = vdda_model;
    b.busy = seq_busy;
    return b;
  endfunction

  function automatic logic [15:0] pick_raw();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8)  return '0;
    if (roll < 16) return 16'($urandom_range(15, 1));
    if (roll < 24) return 16'hFFFF;
    if (roll < 64) return 16'($urandom_range(4095));
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_beat(input logic [1:0] rt, input logic [2:0] ch, input logic [15:0] raw);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= rt;
    req_bus.channel  <= ch;
    req_bus.raw_data <= raw;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    awaited_results.push_back(predict_sequencer_beat(rt, ch, raw));
  endtask

  task automatic send_random_beat();
    int unsigned roll;
    logic [1:0]  rt;
    roll = $urandom_range(99);
    if (seq_busy)
      rt = (roll < 60) ? REQ_COMPLETE : (roll < 78) ? REQ_MEASURE :
           (roll < 95) ? REQ_READ : REQ_RESERVED;
    else
      rt = (roll < 65) ? REQ_MEASURE : (roll < 85) ? REQ_READ :
           (roll < 95) ? REQ_COMPLETE : REQ_RESERVED;
    send_beat(rt, 3'($urandom_range(7)), pick_raw());
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic write_regs(input logic [15:0] res, input logic [31:0] ovs,
                            input logic [11:0] cal);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RESOLUTION;
    cfg_data_i <= {16'b0, res};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OVERSAMPLING;
    cfg_data_i <= ovs;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_VREFINT;
    cfg_data_i <= {20'b0, cal};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    res_cfg = res;
    ovs_cfg = ovs;
    cal_cfg = cal;
  endtask

  // reset settings: idle completes, reserved code, pending and repeat measures
  task automatic test_reset_defaults();
    send_beat(REQ_READ, 3'd0, 16'h0000);
    send_beat(REQ_READ, 3'd7, 16'hFFFF);
    send_beat(REQ_COMPLETE, 3'd2, 16'h1234);
    send_beat(REQ_RESERVED, 3'd5, 16'hFFFF);
    send_beat(REQ_MEASURE, 3'd3, 16'h0000);
    send_beat(REQ_MEASURE, 3'd3, 16'h0000);
    send_beat(REQ_MEASURE, 3'd5, 16'h0000);
    send_beat(REQ_COMPLETE, 3'd0, 16'h0000);
    send_beat(REQ_COMPLETE, 3'd0, 16'hFFFF);
    send_beat(REQ_COMPLETE, 3'd0, 16'h0800);
    send_beat(REQ_COMPLETE, 3'd0, 16'hABCD);
    send_beat(REQ_COMPLETE, 3'd0, 16'h0001);
    send_beat(REQ_COMPLETE, 3'd0, 16'h0000);
    send_beat(REQ_READ, 3'd3, 16'h0000);
  endtask

  // saturated supply, coarsest resolution, clamped oversampling, mixed codes
  task automatic test_register_extremes();
    wait_drained();
    write_regs(16'hFFFF, 32'hFFFF_FFFF, 12'd4095);
    send_beat(REQ_MEASURE, 3'd7, 16'h0000);
    send_beat(REQ_COMPLETE, 3'd7, 16'h0001);
    send_beat(REQ_COMPLETE, 3'd7, 16'hFFFF);
    send_beat(REQ_READ, 3'd7, 16'h0000);
    send_beat(REQ_MEASURE, 3'd0, 16'h0000);
    send_beat(REQ_COMPLETE, 3'd0, 16'hFFFF);
    send_beat(REQ_COMPLETE, 3'd0, 16'h0001);
    wait_drained();
    write_regs(16'hE4E4, 32'h9876_5432, 12'd1650);
    send_beat(REQ_MEASURE, 3'd1, 16'h0000);
    send_beat(REQ_MEASURE, 3'd2, 16'h0000);
    send_beat(REQ_MEASURE, 3'd3, 16'h0000);
    repeat (6) send_beat(REQ_COMPLETE, 3'd0, pick_raw());
  endtask

  task automatic test_random_traffic();
    int ph;
    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        1:       write_regs('0, '0, '0);
        3:       write_regs(16'($urandom), $urandom, 12'd4095);
        default: write_regs(16'($urandom), $urandom, 12'($urandom_range(4095)));
      endcase
      src_idle_on   = (ph != 2);
      sink_stall_on = (ph != 2);
      repeat (PHASE_BEATS) send_random_beat();
    end
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_result_backpressure();
    wait_drained();
    src_idle_on = 1'b0;
    hold_toggle = ~hold_toggle;
    repeat (60) send_random_beat();
    src_idle_on = 1'b1;
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_sender_pause();
    repeat (30) send_random_beat();
    wait_drained();
    repeat (30) send_random_beat();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_RESOLUTION;
    cfg_data_i       <= '0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_MEASURE;
    req_bus.channel  <= '0;
    req_bus.raw_data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_result_backpressure();
    test_sender_pause();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    mismatches += awaited_results.size();
    if (mismatches == 0) begin
      $display("tb_adc_conversion_sequencer: done, clean");
    end else begin
      $display("tb_adc_conversion_sequencer: done, errors");
    end
    $finish;
  end

  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else if (sink_stall_on) begin
        res_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    seq_beat_t want;
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        check_field("start_valid", 16'(want.start_valid), 16'(res_bus.start_valid));
        check_field("start_channel", 16'(want.start_ch), 16'(res_bus.start_channel));
        check_field("start_resolution", 16'(want.start_res),
                    16'(res_bus.start_resolution));
        check_field("start_oversampling", 16'(want.start_ovs),
                    16'(res_bus.start_oversampling));
        check_field("done_valid", 16'(want.done_valid), 16'(res_bus.done_valid));
        check_field("done_channel", 16'(want.done_ch), 16'(res_bus.done_channel));
        check_field("sample_value", want.sample, res_bus.sample_value);
        check_field("voltage_mv", want.volts, res_bus.voltage_mv);
        check_field("vdda_mv", want.vdda, res_bus.vdda_mv);
        check_field("busy_res", 16'(want.busy), 16'(res_bus.busy_res));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_adc_conversion_sequencer: done, errors");
      $finish;
    end
  end

endmodule
